### rtl/c3z_pkg.sv
// Package for the streaming 3x3 convolution core: shared constants, register
// indexes and the result record that crosses the output queue.
// No dependencies.
package c3z_pkg;

  localparam int OUT_BITS      = 36;
  localparam int KREG_BITS     = 48;
  localparam int DIM_REG_BITS  = 9;
  localparam int CFG_DATA_BITS = 48;
  localparam int CFG_IDX_BITS  = 3;
  localparam int MIN_DIM       = 3;
  localparam int TAPS          = 3;

  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  localparam logic [DIM_REG_BITS-1:0] DIM_RESET = 9'd255;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_KERNEL_LEFT  = 3'd0,
    CFG_KERNEL_MID   = 3'd1,
    CFG_KERNEL_RIGHT = 3'd2,
    CFG_IMAGE_WIDTH  = 3'd3,
    CFG_IMAGE_HEIGHT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                       frame_last;
    logic signed [OUT_BITS-1:0] filtered;
  } res_t;

endpackage

### rtl/c3z_if.sv
// Stream interfaces of the 3x3 convolution core: the pixel channel and the
// result channel, both valid/ready. Depends on c3z_pkg.
interface c3z_pix_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   frame_start;
  logic                   pad_item;

  modport source (output valid, sample, frame_start, pad_item, input ready);
  modport sink   (input valid, sample, frame_start, pad_item, output ready);
endinterface

interface c3z_res_if import c3z_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] filtered;
  logic                       frame_last;

  modport source (output valid, filtered, frame_last, input ready);
  modport sink   (input valid, filtered, frame_last, output ready);
endinterface

### rtl/c3z_tap_cell.sv
// One tap of the 3x3 window: holds a sample, hands it to its neighbor on
// each shift and registers its weighted product. No package dependencies.
module c3z_tap_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     shift_i,
  input  logic [SAMPLE_BITS-1:0]                   sample_i,
  input  logic signed [COEF_BITS-1:0]              coef_i,
  input  logic                                     use_i,
  output logic [SAMPLE_BITS-1:0]                   sample_o,
  output logic signed [SAMPLE_BITS+COEF_BITS:0]    prod_o
);

  logic [SAMPLE_BITS-1:0]                sample_q;
  logic signed [SAMPLE_BITS+COEF_BITS:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  // Taps that fall outside the image contribute zero.
  always_ff @(posedge clk_i) begin
    if (use_i) begin
      prod_q <= $signed({1'b0, sample_q}) * coef_i;
    end else begin
      prod_q <= '0;
    end
  end

  assign sample_o = sample_q;
  assign prod_o   = prod_q;

endmodule

### rtl/c3z_line_store.sv
// Two line stores of the 3x3 convolution core, each one row of samples.
// Reads are registered; a bypass covers a read of the address written by
// the previous item. No package dependencies.
module c3z_line_store #(
  parameter int MAX_DIM     = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic [$clog2(MAX_DIM)-1:0] addr_i,
  input  logic [SAMPLE_BITS-1:0]     bot_i,
  output logic [SAMPLE_BITS-1:0]     top_o,
  output logic [SAMPLE_BITS-1:0]     mid_o
);

  localparam int AW = $clog2(MAX_DIM);

  logic [SAMPLE_BITS-1:0] near_mem [MAX_DIM];
  logic [SAMPLE_BITS-1:0] far_mem  [MAX_DIM];

  logic [SAMPLE_BITS-1:0] near_rd_q;
  logic [SAMPLE_BITS-1:0] far_rd_q;
  logic [SAMPLE_BITS-1:0] hit_data_q;
  logic                   hit_q;
  logic [AW-1:0]          wb_addr_q;
  logic                   wb_vld_q;

  // The near row takes the new sample at once; the far row takes what the
  // near row held there in the next cycle, when that read has returned.
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      near_mem[addr_i] <= bot_i;
      near_rd_q        <= near_mem[addr_i];
      far_rd_q         <= far_mem[addr_i];
      hit_q            <= wb_vld_q && (wb_addr_q == addr_i);
      hit_data_q       <= near_rd_q;
      wb_addr_q        <= addr_i;
    end
    if (wb_vld_q) begin
      far_mem[wb_addr_q] <= near_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_vld_q <= 1'b0;
    end else begin
      wb_vld_q <= take_i;
    end
  end

  assign mid_o = near_rd_q;
  assign top_o = hit_q ? hit_data_q : far_rd_q;

endmodule

### rtl/c3z_out_fifo.sv
// Result queue of the 3x3 convolution core; drives the result channel from
// registered entries. Depends on c3z_pkg and c3z_res_if.
module c3z_out_fifo import c3z_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  res_t                     push_data_i,
  c3z_res_if.source                res_o,
  output logic [FIFO_CNT_BITS-1:0] count_o
);

  res_t                     mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
  logic [FIFO_CNT_BITS-1:0] cnt_q;
  logic                     pop;

  assign pop = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
      end
      cnt_q <= cnt_q + FIFO_CNT_BITS'(push_i) - FIFO_CNT_BITS'(pop);
    end
  end

  assign res_o.valid      = (cnt_q != '0);
  assign res_o.filtered   = mem[rd_ptr_q].filtered;
  assign res_o.frame_last = mem[rd_ptr_q].frame_last;
  assign count_o          = cnt_q;

endmodule

### rtl/conv3x3_zero_border_core.sv
// Streaming 3x3 convolution with zero border, one pixel per clock cycle while input ready is high.
// A result enters the output queue once the item that completes its window
// has passed line store read, window shift, multiply and two adder levels.
// Input ready drops once the 8-entry result queue and the pipeline hold 8.
// Reset is asynchronous: counters, window, pipeline and queue clear and the
// registers take their reset values; line stores are not cleared.
module conv3x3_zero_border_core import c3z_pkg::*; #(
  parameter int MAX_DIM     = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  c3z_pix_if.sink                  pix_i,
  c3z_res_if.source                res_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int CW  = $clog2(MAX_DIM);
  localparam int RW  = $clog2(MAX_DIM + 2);
  localparam int DCW = (RW > DIM_REG_BITS) ? RW : DIM_REG_BITS;
  localparam int PW  = SAMPLE_BITS + COEF_BITS + 1;

  typedef struct packed {
    logic emit;
    logic use_left;
    logic use_right;
    logic use_top;
    logic use_bot;
    logic last;
  } tap_mask_t;

  // Configuration registers.
  logic [KREG_BITS-1:0]    kern_q [TAPS];
  logic [DIM_REG_BITS-1:0] width_q;
  logic [DIM_REG_BITS-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q[0] <= '0;
      kern_q[1] <= '0;
      kern_q[2] <= '0;
      width_q   <= DIM_RESET;
      height_q  <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KERNEL_LEFT:  kern_q[0] <= cfg_data_i[KREG_BITS-1:0];
        CFG_KERNEL_MID:   kern_q[1] <= cfg_data_i[KREG_BITS-1:0];
        CFG_KERNEL_RIGHT: kern_q[2] <= cfg_data_i[KREG_BITS-1:0];
        CFG_IMAGE_WIDTH:  width_q   <= cfg_data_i[DIM_REG_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_q  <= cfg_data_i[DIM_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [RW-1:0] clamp_dim(input logic [DIM_REG_BITS-1:0] v);
    logic [DCW-1:0] e;
    e = DCW'(v);
    if (e < DCW'(MIN_DIM)) begin
      return RW'(MIN_DIM);
    end else if (e > DCW'(MAX_DIM)) begin
      return RW'(MAX_DIM);
    end
    return e[RW-1:0];
  endfunction

  logic [RW-1:0] img_h;
  logic [RW-1:0] w_m1;
  logic [RW-1:0] h_m1;

  assign img_h = clamp_dim(height_q);
  assign w_m1  = clamp_dim(width_q) - RW'(1);
  assign h_m1  = img_h - RW'(1);

  // Position counters and the decision for each accepted item.
  logic [CW-1:0] in_col_q, in_col_d, ic;
  logic [RW-1:0] in_row_q, in_row_d, ir;
  logic [CW-1:0] out_col_q, out_col_d, oc;
  logic [RW-1:0] out_row_q, out_row_d, orow;

  logic                   accept;
  logic                   take;
  logic                   emit;
  logic                   col_wrap;
  logic                   ocol_wrap;
  logic [SAMPLE_BITS-1:0] bot;
  tap_mask_t              mask_a;

  logic [FIFO_CNT_BITS-1:0] fifo_cnt;
  logic [FIFO_CNT_BITS-1:0] inflight;

  assign accept = pix_i.valid && pix_i.ready;

  always_comb begin
    ic   = pix_i.frame_start ? '0 : in_col_q;
    ir   = pix_i.frame_start ? '0 : in_row_q;
    oc   = pix_i.frame_start ? '0 : out_col_q;
    orow = pix_i.frame_start ? '0 : out_row_q;

    // Items are dropped once the frame has been fully emitted, and pads
    // count only after the last real row.
    take = accept && (orow < img_h) &&
           (pix_i.pad_item ? (ir >= img_h) : (ir < img_h));
    emit = (ir >= RW'(2)) || ((ir == RW'(1)) && (ic != '0));
    col_wrap  = (RW'(ic) >= w_m1);
    ocol_wrap = (RW'(oc) >= w_m1);
    bot = pix_i.pad_item ? '0 : pix_i.sample;

    mask_a.emit      = emit;
    mask_a.use_left  = (oc != '0);
    mask_a.use_right = !ocol_wrap;
    mask_a.use_top   = (orow != '0);
    mask_a.use_bot   = (orow < h_m1);
    mask_a.last      = ocol_wrap && (orow >= h_m1);

    in_col_d  = ic;
    in_row_d  = ir;
    out_col_d = oc;
    out_row_d = orow;
    if (take) begin
      if (col_wrap) begin
        in_col_d = '0;
        in_row_d = ir + RW'(1);
      end else begin
        in_col_d = ic + CW'(1);
      end
      if (emit) begin
        if (ocol_wrap) begin
          out_col_d = '0;
          out_row_d = orow + RW'(1);
        end else begin
          out_col_d = oc + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (accept) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // Line stores.
  logic [SAMPLE_BITS-1:0] top_b;
  logic [SAMPLE_BITS-1:0] mid_b;

  c3z_line_store #(
    .MAX_DIM     (MAX_DIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_line_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .addr_i (ic),
    .bot_i  (bot),
    .top_o  (top_b),
    .mid_o  (mid_b)
  );

  // Pipeline control: B holds the item while its line store reads return,
  // C the window that was just shifted, P the products, R the row sums.
  logic                   vb_q, vc_q, vp_q, vr_q;
  tap_mask_t              mask_b_q, mask_c_q;
  logic                   last_p_q, last_r_q;
  logic [SAMPLE_BITS-1:0] bot_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vp_q <= 1'b0;
      vr_q <= 1'b0;
    end else begin
      vb_q <= take;
      vc_q <= vb_q && mask_b_q.emit;
      vp_q <= vc_q;
      vr_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mask_b_q <= mask_a;
      bot_b_q  <= bot;
    end
    mask_c_q <= mask_b_q;
    last_p_q <= mask_c_q.last;
    last_r_q <= last_p_q;
  end

  // Window: three chains of three cells, newest column at index 2.
  logic [SAMPLE_BITS-1:0] win    [TAPS][TAPS];
  logic [SAMPLE_BITS-1:0] feed   [TAPS];
  logic signed [PW-1:0]   prod   [TAPS][TAPS];
  logic                   row_en [TAPS];
  logic                   col_en [TAPS];

  assign feed[0]   = top_b;
  assign feed[1]   = mid_b;
  assign feed[2]   = bot_b_q;
  assign row_en[0] = mask_c_q.use_top;
  assign row_en[1] = 1'b1;
  assign row_en[2] = mask_c_q.use_bot;
  assign col_en[0] = mask_c_q.use_left;
  assign col_en[1] = 1'b1;
  assign col_en[2] = mask_c_q.use_right;

  for (genvar r = 0; r < TAPS; r++) begin : g_row
    for (genvar c = 0; c < TAPS; c++) begin : g_col
      logic [SAMPLE_BITS-1:0] cell_in;
      if (c == TAPS - 1) begin : g_head
        assign cell_in = feed[r];
      end else begin : g_link
        assign cell_in = win[r][c+1];
      end

      c3z_tap_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (vb_q),
        .sample_i (cell_in),
        .coef_i   ($signed(kern_q[c][r*COEF_BITS +: COEF_BITS])),
        .use_i    (vc_q && row_en[r] && col_en[c]),
        .sample_o (win[r][c]),
        .prod_o   (prod[r][c])
      );
    end
  end

  // Adder tree: row sums, then the final sum into the queue.
  logic signed [OUT_BITS-1:0] rsum_q [TAPS];
  res_t                       push_data;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < TAPS; r++) begin
      rsum_q[r] <= OUT_BITS'(prod[r][0]) + OUT_BITS'(prod[r][1]) +
                   OUT_BITS'(prod[r][2]);
    end
  end

  assign push_data.filtered   = rsum_q[0] + rsum_q[1] + rsum_q[2];
  assign push_data.frame_last = last_r_q;

  c3z_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (vr_q),
    .push_data_i (push_data),
    .res_o       (res_o),
    .count_o     (fifo_cnt)
  );

  // Every result in the pipeline has a queue entry reserved for it.
  assign inflight = FIFO_CNT_BITS'(vb_q && mask_b_q.emit) + FIFO_CNT_BITS'(vc_q) +
                    FIFO_CNT_BITS'(vp_q) + FIFO_CNT_BITS'(vr_q);
  assign pix_i.ready = ((fifo_cnt + inflight) < FIFO_CNT_BITS'(FIFO_DEPTH));

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_cnt + inflight) <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("result queue overrun");

  a_push_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vr_q |-> $past(pix_i.valid && pix_i.ready, 4))
    else $error("result pushed without a matching transfer");

  a_shift_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> $past(pix_i.valid && pix_i.ready))
    else $error("window shifted without a transfer");

endmodule
